// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge, off during reset
`define EFD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// same-cycle implication
`define EFD_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication failed");

`endif

// File: design/efd_pkg.sv
// ----------------------------------------------------------------------------
// efd_pkg
// Types and constants of the error diffusion dither.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam int GrayW       = 8;
  localparam int LineWidthW  = 11;
  localparam int ThresholdW  = 8;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 11;

  localparam int MaxLineDef   = 1024;
  localparam int ErrorBitsDef = 14;

  localparam logic [LineWidthW-1:0] LineWidthRst = 11'd640;
  localparam logic [ThresholdW-1:0] ThresholdRst = 8'd128;

  // full white level in Q.4 gray units
  localparam int FullScale = 255 * 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLineWidth = 1'b0,
    CfgThreshold = 1'b1
  } efd_cfg_e;

  typedef struct packed {
    logic [GrayW-1:0] gray_level;
    logic             frame_start;
  } efd_in_t;

  typedef struct packed {
    logic out_bit;
    logic line_end;
  } efd_out_t;

endpackage

// File: design/efd_line_store.sv
// ----------------------------------------------------------------------------
// efd_line_store
// Next-row error store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module efd_line_store #(
  parameter int DEPTH = efd_pkg::MaxLineDef,
  parameter int DW    = efd_pkg::ErrorBitsDef
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Floyd-Steinberg dither of an 8-bit gray raster stream to one bit per pixel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained, while the output side is not stalled;
// each result passes the stage 1 registers and the output register. The rate
// is set by the line store: each pixel reads its column at the input beat and,
// when it leaves stage 1, writes the finished sum of the column to its left
// back, so one read and one write port suffice; the last pixel of a line writes
// its own column from a deferred register, a slot the first pixel of the next line leaves free.
// Pending writes are forwarded to the reading pixel. The store needs no
// clearing after reset: the first line after frame_start reads it as zero.
// Configuration writes are taken at once (ready is always high).
module error_diffusion_dither #(
  parameter int MAX_LINE   = efd_pkg::MaxLineDef,
  parameter int ERROR_BITS = efd_pkg::ErrorBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  efd_pkg::efd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output efd_pkg::efd_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [efd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [efd_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int XW = (AW + 1 > efd_pkg::LineWidthW) ? AW + 1 : efd_pkg::LineWidthW;
  localparam int EB = ERROR_BITS;
  localparam int SW = ERROR_BITS + 3;

  localparam logic signed [SW-1:0] ErrHi = SW'(2 ** (ERROR_BITS - 1) - 1);
  localparam logic signed [SW-1:0] ErrLo = -ErrHi - SW'(1);
  localparam logic signed [SW-1:0] FullSw = SW'(efd_pkg::FullScale);

  function automatic logic signed [EB-1:0] sat_err(input logic signed [SW-1:0] v);
    if (v > ErrHi) begin
      return ErrHi[EB-1:0];
    end else if (v < ErrLo) begin
      return ErrLo[EB-1:0];
    end
    return v[EB-1:0];
  endfunction

  // configuration
  logic [efd_pkg::LineWidthW-1:0] line_width_q;
  logic [efd_pkg::ThresholdW-1:0] threshold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= efd_pkg::LineWidthRst;
      threshold_q  <= efd_pkg::ThresholdRst;
    end else if (cfg_valid_i) begin
      case (efd_pkg::efd_cfg_e'(cfg_index_i))
        efd_pkg::CfgLineWidth: line_width_q <= cfg_data_i[efd_pkg::LineWidthW-1:0];
        efd_pkg::CfgThreshold: threshold_q  <= cfg_data_i[efd_pkg::ThresholdW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_valid_q;
  logic s1_adv;
  logic in_acc;
  logic out_valid_q;
  efd_pkg::efd_out_t out_data_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // stage 0: column bookkeeping and line store read
  logic [AW-1:0] column_count_q, column_count_d;
  logic          first_row_q, first_row_d;
  logic [XW-1:0] lw_x, w_x, cnt_x, col_x;
  logic          s0_first, s0_last;
  logic [AW-1:0] s0_col;

  always_comb begin
    lw_x = XW'(line_width_q);
    if (lw_x == '0) begin
      w_x = XW'(1);
    end else if (lw_x > XW'(MAX_LINE)) begin
      w_x = XW'(MAX_LINE);
    end else begin
      w_x = lw_x;
    end
    cnt_x    = in_data_i.frame_start ? '0 : XW'(column_count_q);
    col_x    = (cnt_x >= w_x) ? w_x - XW'(1) : cnt_x;
    s0_last  = (col_x + XW'(1) >= w_x);
    s0_col   = col_x[AW-1:0];
    s0_first = in_data_i.frame_start || first_row_q;
    column_count_d = s0_last ? '0 : AW'(col_x + XW'(1));
    first_row_d    = s0_last ? 1'b0 : s0_first;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      first_row_q    <= 1'b1;
    end else if (in_acc) begin
      column_count_q <= column_count_d;
      first_row_q    <= first_row_d;
    end
  end

  // stage 1 item registers
  logic [efd_pkg::GrayW-1:0] s1_gray_q;
  logic [AW-1:0]             s1_col_q;
  logic                      s1_last_q, s1_first_q, s1_fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_gray_q  <= in_data_i.gray_level;
      s1_col_q   <= s0_col;
      s1_last_q  <= s0_last;
      s1_first_q <= s0_first;
      s1_fs_q    <= in_data_i.frame_start;
    end
  end

  // line store and write-back
  logic          we;
  logic [AW-1:0] waddr;
  logic [EB-1:0] wdata, rdata;
  logic          dfr_valid_q;
  logic [AW-1:0] dfr_addr_q;
  logic [EB-1:0] dfr_data_q;
  logic          fwd_valid_q;
  logic [EB-1:0] fwd_data_q;
  logic          s1_wr;
  logic signed [EB-1:0] left_sum, bp0_new;

  efd_line_store #(
    .DEPTH (MAX_LINE),
    .DW    (EB)
  ) u_line_store (
    .clk_i   (clk_i),
    .re_i    (in_acc),
    .raddr_i (s0_col),
    .rdata_o (rdata),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  assign s1_wr = s1_adv && (s1_col_q != '0);
  assign we    = dfr_valid_q || s1_wr;
  assign waddr = dfr_valid_q ? dfr_addr_q : s1_col_q - AW'(1);
  assign wdata = dfr_valid_q ? dfr_data_q : left_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfr_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      dfr_valid_q <= s1_adv && s1_last_q;
      if (in_acc) begin
        fwd_valid_q <= we && (waddr == s0_col);
      end else if (we && (waddr == s1_col_q)) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      dfr_addr_q <= s1_col_q;
      dfr_data_q <= bp0_new;
    end
    if (in_acc ? (we && (waddr == s0_col)) : (we && (waddr == s1_col_q))) begin
      fwd_data_q <= wdata;
    end
  end

  // stage 1 datapath
  logic signed [EB-1:0] right_q, bp0_q, bp1_q;
  logic signed [EB-1:0] re_v, p0_v, p1_v, above, e;
  logic signed [SW-1:0] cx, thx, ex, e7, e5, e3;
  logic signed [EB-1:0] s7, s5, s3, s1;
  logic                 bit_v;

  always_comb begin
    re_v = s1_fs_q ? '0 : right_q;
    p0_v = s1_fs_q ? '0 : bp0_q;
    p1_v = s1_fs_q ? '0 : bp1_q;
    if (s1_first_q) begin
      above = '0;
    end else if (dfr_valid_q && (dfr_addr_q == s1_col_q)) begin
      above = dfr_data_q;
    end else if (fwd_valid_q) begin
      above = fwd_data_q;
    end else begin
      above = rdata;
    end
    cx    = $signed({{(SW - efd_pkg::GrayW - 4){1'b0}}, s1_gray_q, 4'b0000})
            + SW'(re_v) + SW'(above);
    thx   = $signed({{(SW - efd_pkg::ThresholdW - 4){1'b0}}, threshold_q, 4'b0000});
    bit_v = (cx >= thx);
    e     = sat_err(bit_v ? cx - FullSw : cx);
    ex    = SW'(e);
    e7    = (ex <<< 3) - ex;
    e5    = (ex <<< 2) + ex;
    e3    = (ex <<< 1) + ex;
    s7    = EB'(e7 >>> 4);
    s5    = EB'(e5 >>> 4);
    s3    = EB'(e3 >>> 4);
    s1    = EB'(ex >>> 4);
    left_sum = sat_err(SW'(p0_v) + SW'(s3));
    bp0_new  = sat_err(SW'(p1_v) + SW'(s5));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      bp0_q   <= '0;
      bp1_q   <= '0;
    end else if (s1_adv) begin
      right_q <= s1_last_q ? '0 : s7;
      bp0_q   <= s1_last_q ? '0 : bp0_new;
      bp1_q   <= s1_last_q ? '0 : s1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q.out_bit  <= bit_v;
      out_data_q.line_end <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/efd_checker.sv
// ----------------------------------------------------------------------------
// efd_checker
// Port-level checks of the dither, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module efd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input efd_pkg::efd_out_t out_data_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);

  // a stalled result beat holds
  `EFD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // input backpressure only comes from a full, stalled output
  `EFD_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // an accepted input beat is followed by an offered output beat
  `EFD_ASSERT(a_result_follows, clk_i, rst_ni, in_valid_i && !in_stall_o |=> ##1 out_valid_o)

  // register writes never wait
  `EFD_ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

endmodule

bind error_diffusion_dither efd_checker u_efd_checker (.*);
